// ===== design/wsfp_pkg.sv =====
package wsfp_pkg;

    localparam int unsigned PhaseW = 5;
    localparam int unsigned LenW   = 64;

    localparam logic [PhaseW-1:0] PH_START   = 5'd0;
    localparam logic [PhaseW-1:0] PH_LEN     = 5'd1;
    localparam logic [PhaseW-1:0] PH_L16A    = 5'd2;
    localparam logic [PhaseW-1:0] PH_L16B    = 5'd3;
    localparam logic [PhaseW-1:0] PH_L64A    = 5'd4;
    localparam logic [PhaseW-1:0] PH_L64H    = 5'd11;
    localparam logic [PhaseW-1:0] PH_KEY0    = 5'd12;
    localparam logic [PhaseW-1:0] PH_KEY3    = 5'd15;
    localparam logic [PhaseW-1:0] PH_PAYLOAD = 5'd16;

    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_REJECT  = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BAD_OP = 2'd1;
    localparam logic [1:0] ST_CLOSED = 2'd2;

    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PONG   = 4'hA;

    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

    typedef logic [7:0] t_byte;

    function automatic logic opcode_ok(input logic [3:0] op);
        return (op <= OP_BINARY) || ((op >= OP_CLOSE) && (op <= OP_PONG));
    endfunction

endpackage

// ===== design/websocket_frame_parser.sv =====
// WebSocket frame parser: one received byte per transaction in, one result out.
// Each accepted byte passes the input register, then the result register.
// Throughput: one byte per cycle unless i_ready stalls the result register;
// the header/length/payload state advances per byte.
// Reset: synchronous, active low; clears all parser state and both pipeline stages.
module websocket_frame_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_byte_kind,
    output logic [7:0]  o_payload_out,
    output logic        o_frame_first,
    output logic        o_frame_last,
    output logic        o_fin_flag,
    output logic [3:0]  o_frame_opcode,
    output logic [63:0] o_frame_length,
    output logic [1:0]  o_status
);

    // input stage
    logic                 r_s1_valid;
    wsfp_pkg::t_byte      r_s1_byte;
    logic                 advance;

    // parser state
    logic [wsfp_pkg::PhaseW-1:0] r_phase, n_phase;
    logic                        r_fin, n_fin;
    logic [3:0]                  r_op, n_op;
    logic                        r_masked, n_masked;
    logic [wsfp_pkg::LenW-1:0]   r_len, n_len;
    logic [wsfp_pkg::LenW-1:0]   r_remain, n_remain;
    wsfp_pkg::t_byte             r_key [4];
    wsfp_pkg::t_byte             n_key [4];
    logic [1:0]                  r_pos, n_pos;
    logic                        r_err, n_err;
    logic                        r_close, n_close;

    // result stage
    logic                        r_out_valid;
    logic [1:0]                  r_kind, n_kind;
    wsfp_pkg::t_byte             r_pay, n_pay;
    logic                        r_first, n_first;
    logic                        r_last, n_last;
    logic                        r_ofin, n_ofin;
    logic [3:0]                  r_oop, n_oop;
    logic [wsfp_pkg::LenW-1:0]   r_olen, n_olen;
    logic [1:0]                  r_stat, n_stat;

    logic                        len_done;
    logic                        done;
    wsfp_pkg::t_byte             b;

    assign advance = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_s1_valid || advance;
    assign b       = r_s1_byte;

    always_comb begin
        n_phase  = r_phase;
        n_fin    = r_fin;
        n_op     = r_op;
        n_masked = r_masked;
        n_len    = r_len;
        n_remain = r_remain;
        n_key    = r_key;
        n_pos    = r_pos;
        n_err    = r_err;
        n_close  = r_close;
        n_kind   = wsfp_pkg::KIND_HEADER;
        n_pay    = '0;
        n_first  = 1'b0;
        n_last   = 1'b0;
        n_stat   = wsfp_pkg::ST_OK;
        len_done = 1'b0;
        done     = 1'b0;

        if (r_err || r_close) begin
            n_kind = wsfp_pkg::KIND_REJECT;
            n_stat = r_err ? wsfp_pkg::ST_BAD_OP : wsfp_pkg::ST_CLOSED;
        end else if (r_phase == wsfp_pkg::PH_START) begin
            n_fin = b[7];
            n_op  = b[3:0];
            if (!wsfp_pkg::opcode_ok(b[3:0])) begin
                n_err  = 1'b1;
                n_kind = wsfp_pkg::KIND_REJECT;
                n_stat = wsfp_pkg::ST_BAD_OP;
            end else begin
                n_first = 1'b1;
                n_phase = wsfp_pkg::PH_LEN;
            end
        end else if (r_phase == wsfp_pkg::PH_LEN) begin
            n_masked = b[7];
            if (b[6:0] == wsfp_pkg::LEN7_EXT16) begin
                n_len   = '0;
                n_phase = wsfp_pkg::PH_L16A;
            end else if (b[6:0] == wsfp_pkg::LEN7_EXT64) begin
                n_len   = '0;
                n_phase = wsfp_pkg::PH_L64A;
            end else begin
                n_len    = {{(wsfp_pkg::LenW-7){1'b0}}, b[6:0]};
                len_done = 1'b1;
            end
        end else if (r_phase == wsfp_pkg::PH_L16A) begin
            n_len   = {{(wsfp_pkg::LenW-16){1'b0}}, b, 8'h00};
            n_phase = wsfp_pkg::PH_L16B;
        end else if (r_phase == wsfp_pkg::PH_L16B) begin
            n_len    = {r_len[wsfp_pkg::LenW-1:8], b};
            len_done = 1'b1;
        end else if (r_phase >= wsfp_pkg::PH_L64A && r_phase <= wsfp_pkg::PH_L64H) begin
            n_len = {r_len[wsfp_pkg::LenW-9:0], b};
            if (r_phase == wsfp_pkg::PH_L64H) begin
                len_done = 1'b1;
            end else begin
                n_phase = r_phase + 5'd1;
            end
        end else if (r_phase >= wsfp_pkg::PH_KEY0 && r_phase <= wsfp_pkg::PH_KEY3) begin
            n_key[r_phase[1:0]] = b;
            if (r_phase == wsfp_pkg::PH_KEY0) begin
                n_pos = 2'd0;
            end
            if (r_phase == wsfp_pkg::PH_KEY3) begin
                if (r_len == '0) begin
                    done = 1'b1;
                end else begin
                    n_phase  = wsfp_pkg::PH_PAYLOAD;
                    n_remain = r_len;
                end
            end else begin
                n_phase = r_phase + 5'd1;
            end
        end else if (r_phase == wsfp_pkg::PH_PAYLOAD) begin
            n_kind = wsfp_pkg::KIND_PAYLOAD;
            if (r_masked) begin
                n_pay = b ^ r_key[r_pos];
                n_pos = r_pos + 2'd1;
            end else begin
                n_pay = b;
            end
            n_remain = r_remain - 64'd1;
            if (r_remain <= 64'd1) begin
                done = 1'b1;
            end
        end else begin
            n_phase = wsfp_pkg::PH_START;
        end

        if (len_done) begin
            if (n_masked) begin
                n_phase = wsfp_pkg::PH_KEY0;
            end else begin
                n_pos = 2'd0;
                for (int k = 0; k < 4; k++) begin
                    n_key[k] = '0;
                end
                if (n_len == '0) begin
                    done = 1'b1;
                end else begin
                    n_phase  = wsfp_pkg::PH_PAYLOAD;
                    n_remain = n_len;
                end
            end
        end

        if (done) begin
            n_last = 1'b1;
            if (n_op == wsfp_pkg::OP_CLOSE) begin
                n_close = 1'b1;
            end
        end

        // fields show the frame before the end-of-frame clear
        n_ofin = n_fin;
        n_oop  = n_op;
        n_olen = n_len;

        if (done) begin
            n_phase  = wsfp_pkg::PH_START;
            n_fin    = 1'b0;
            n_op     = '0;
            n_masked = 1'b0;
            n_len    = '0;
            n_pos    = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= wsfp_pkg::PH_START;
            r_fin       <= 1'b0;
            r_op        <= '0;
            r_masked    <= 1'b0;
            r_len       <= '0;
            r_remain    <= '0;
            r_pos       <= 2'd0;
            r_err       <= 1'b0;
            r_close     <= 1'b0;
            for (int k = 0; k < 4; k++) begin
                r_key[k] <= '0;
            end
        end else begin
            if (o_ready) begin
                r_s1_valid <= i_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (advance) begin
                r_phase  <= n_phase;
                r_fin    <= n_fin;
                r_op     <= n_op;
                r_masked <= n_masked;
                r_len    <= n_len;
                r_remain <= n_remain;
                r_key    <= n_key;
                r_pos    <= n_pos;
                r_err    <= n_err;
                r_close  <= n_close;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_s1_byte <= i_rx_byte;
        end
        if (advance) begin
            r_kind  <= n_kind;
            r_pay   <= n_pay;
            r_first <= n_first;
            r_last  <= n_last;
            r_ofin  <= n_ofin;
            r_oop   <= n_oop;
            r_olen  <= n_olen;
            r_stat  <= n_stat;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_byte_kind    = r_kind;
    assign o_payload_out  = r_pay;
    assign o_frame_first  = r_first;
    assign o_frame_last   = r_last;
    assign o_fin_flag     = r_ofin;
    assign o_frame_opcode = r_oop;
    assign o_frame_length = r_olen;
    assign o_status       = r_stat;

endmodule

// ===== bench/tb_websocket_frame_parser.sv =====
`timescale 1ns / 1ps

module tb_websocket_frame_parser;

    localparam logic [3:0] OP_CONT = 4'h0;
    localparam logic [3:0] OP_TEXT = 4'h1;
    localparam logic [3:0] OP_PING = 4'h9;

    localparam int ENC_LEN7  = 0;
    localparam int ENC_LEN16 = 1;
    localparam int ENC_LEN64 = 2;

    localparam int ITEMS_PER_PHASE = 130;
    localparam int HOLD_CYCLES     = 64;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int DRAIN_CYCLES    = 8;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic        first;
        logic        last;
        logic        fin;
        logic [3:0]  op;
        logic [63:0] len;
        logic [1:0]  st;
    } t_frame_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_byte_kind;
    logic [7:0]  o_payload_out;
    logic        o_frame_first;
    logic        o_frame_last;
    logic        o_fin_flag;
    logic [3:0]  o_frame_opcode;
    logic [63:0] o_frame_length;
    logic [1:0]  o_status;

    websocket_frame_parser dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_byte_kind    (o_byte_kind),
        .o_payload_out  (o_payload_out),
        .o_frame_first  (o_frame_first),
        .o_frame_last   (o_frame_last),
        .o_fin_flag     (o_fin_flag),
        .o_frame_opcode (o_frame_opcode),
        .o_frame_length (o_frame_length),
        .o_status       (o_status)
    );

    always #1 i_clk = ~i_clk;

    // deframer state as predicted
    logic [4:0]  p_phase = wsfp_pkg::PH_START;
    logic        p_fin = 1'b0;
    logic [3:0]  p_op = 4'h0;
    logic        p_masked = 1'b0;
    logic [63:0] p_len = 64'd0;
    logic [63:0] p_count = 64'd0;
    logic [7:0]  p_key [4] = '{default: 8'h00};
    logic [1:0]  p_kpos = 2'd0;
    logic        p_err = 1'b0;
    logic        p_closed = 1'b0;

    t_frame_res  expected_q [$];
    t_frame_res  want;
    int          n_mismatch = 0;
    int          n_sent = 0;
    int          quiet_cycles = 0;
    int          tx_gap_pct = 0;
    int          rx_stall_pct = 0;
    logic        hold_req = 1'b0;

    function automatic logic op_legal(input logic [3:0] op);
        return op inside {OP_CONT, OP_TEXT, wsfp_pkg::OP_BINARY, wsfp_pkg::OP_CLOSE,
                          OP_PING, wsfp_pkg::OP_PONG};
    endfunction

    function automatic logic len_known();
        p_count = 64'd0;
        if (p_masked) begin
            p_phase = wsfp_pkg::PH_KEY0;
            return 1'b0;
        end
        p_kpos = 2'd0;
        foreach (p_key[k]) p_key[k] = 8'h00;
        if (p_len == 64'd0) return 1'b1;
        p_phase = wsfp_pkg::PH_PAYLOAD;
        return 1'b0;
    endfunction

    function automatic t_frame_res deframe(input logic [7:0] b);
        t_frame_res r;
        logic done;
        logic [4:0] slot;
        r = '0;
        done = 1'b0;
        if (p_err || p_closed) begin
            r.kind = wsfp_pkg::KIND_REJECT;
            r.st = p_err ? wsfp_pkg::ST_BAD_OP : wsfp_pkg::ST_CLOSED;
        end else if (p_phase == wsfp_pkg::PH_START) begin
            p_fin = b[7];
            p_op = b[3:0];
            if (!op_legal(p_op)) begin
                p_err = 1'b1;
                r.kind = wsfp_pkg::KIND_REJECT;
                r.st = wsfp_pkg::ST_BAD_OP;
            end else begin
                r.first = 1'b1;
                p_phase = wsfp_pkg::PH_LEN;
            end
        end else if (p_phase == wsfp_pkg::PH_LEN) begin
            p_masked = b[7];
            p_len = 64'd0;
            if (b[6:0] == wsfp_pkg::LEN7_EXT16) begin
                p_phase = wsfp_pkg::PH_L16A;
            end else if (b[6:0] == wsfp_pkg::LEN7_EXT64) begin
                p_phase = wsfp_pkg::PH_L64A;
            end else begin
                p_len = {57'd0, b[6:0]};
                done = len_known();
            end
        end else if (p_phase == wsfp_pkg::PH_L16A) begin
            p_len = {48'd0, b, 8'h00};
            p_phase = wsfp_pkg::PH_L16B;
        end else if (p_phase == wsfp_pkg::PH_L16B) begin
            p_len = p_len | {56'd0, b};
            done = len_known();
        end else if (p_phase >= wsfp_pkg::PH_L64A && p_phase <= wsfp_pkg::PH_L64H) begin
            p_len = {p_len[55:0], b};
            if (p_phase == wsfp_pkg::PH_L64H) done = len_known();
            else p_phase = p_phase + 5'd1;
        end else if (p_phase >= wsfp_pkg::PH_KEY0 && p_phase <= wsfp_pkg::PH_KEY3) begin
            slot = p_phase - wsfp_pkg::PH_KEY0;
            p_key[slot[1:0]] = b;
            if (p_phase == wsfp_pkg::PH_KEY0) p_kpos = 2'd0;
            if (p_phase == wsfp_pkg::PH_KEY3) begin
                p_count = 64'd0;
                if (p_len == 64'd0) done = 1'b1;
                else p_phase = wsfp_pkg::PH_PAYLOAD;
            end else begin
                p_phase = p_phase + 5'd1;
            end
        end else if (p_phase == wsfp_pkg::PH_PAYLOAD) begin
            r.kind = wsfp_pkg::KIND_PAYLOAD;
            if (p_masked) begin
                r.data = b ^ p_key[p_kpos];
                p_kpos = p_kpos + 2'd1;
            end else begin
                r.data = b;
            end
            p_count = p_count + 64'd1;
            if (p_count >= p_len) done = 1'b1;
        end else begin
            p_phase = wsfp_pkg::PH_START;
        end

        if (done) begin
            r.last = 1'b1;
            if (p_op == wsfp_pkg::OP_CLOSE) p_closed = 1'b1;
        end
        r.fin = p_fin;
        r.op = p_op;
        r.len = p_len;
        if (done) begin
            p_phase = wsfp_pkg::PH_START;
            p_fin = 1'b0;
            p_op = 4'h0;
            p_masked = 1'b0;
            p_len = 64'd0;
            p_count = 64'd0;
            p_kpos = 2'd0;
        end
        return r;
    endfunction

    // entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < tx_gap_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        expected_q.push_back(deframe(b));
        n_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_frame(input logic fin, input logic [3:0] op, input logic mask,
                              input int enc, input logic [63:0] len, input int n_pay);
        logic [2:0] rsv;
        logic [6:0] l7;
        rsv = 3'($urandom);
        send_byte({fin, rsv, op});
        if (enc == ENC_LEN16) l7 = wsfp_pkg::LEN7_EXT16;
        else if (enc == ENC_LEN64) l7 = wsfp_pkg::LEN7_EXT64;
        else l7 = len[6:0];
        send_byte({mask, l7});
        if (enc == ENC_LEN16) begin
            send_byte(len[15:8]);
            send_byte(len[7:0]);
        end else if (enc == ENC_LEN64) begin
            for (int i = 7; i >= 0; i--) send_byte(len[8*i +: 8]);
        end
        if (mask) for (int i = 0; i < 4; i++) send_byte(8'($urandom));
        for (int i = 0; i < n_pay; i++) send_byte(8'($urandom));
    endtask

    function automatic logic [3:0] any_data_op();
        case ($urandom_range(4))
            0: return OP_CONT;
            1: return OP_TEXT;
            2: return wsfp_pkg::OP_BINARY;
            3: return OP_PING;
            default: return wsfp_pkg::OP_PONG;
        endcase
    endfunction

    task automatic test_empty_frames();
        send_frame(1'b1, OP_TEXT, 1'b0, ENC_LEN7, 64'd0, 0);
        send_frame(1'b0, OP_CONT, 1'b1, ENC_LEN7, 64'd0, 0);
    endtask

    task automatic test_payload_extremes();
        send_byte({1'b1, 3'b000, wsfp_pkg::OP_BINARY});
        send_byte(8'd2);
        send_byte(8'h00);
        send_byte(8'hFF);
    endtask

    task automatic test_ext_lengths();
        send_frame(1'b1, OP_PING, 1'b0, ENC_LEN16, 64'd1, 1);
        send_frame(1'b0, wsfp_pkg::OP_PONG, 1'b0, ENC_LEN64, 64'd0, 0);
    endtask

    task automatic test_random_frames(input int upto);
        int sel;
        int enc;
        logic [63:0] len;
        while (n_sent < upto) begin
            sel = $urandom_range(99);
            if (sel < 5) begin
                enc = ENC_LEN7;
                len = 64'd125;
            end else if (sel < 70) begin
                enc = ENC_LEN7;
                len = ($urandom_range(3) == 0) ? 64'($urandom_range(125))
                                               : 64'($urandom_range(12));
            end else if (sel < 85) begin
                enc = ENC_LEN16;
                len = 64'($urandom_range(140));
            end else begin
                enc = ENC_LEN64;
                len = 64'($urandom_range(20));
            end
            send_frame(1'($urandom_range(1)), any_data_op(), 1'($urandom_range(1)), enc,
                       len, int'(len));
        end
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        send_frame(1'b1, wsfp_pkg::OP_BINARY, 1'b1, ENC_LEN16, 64'd100, 100);
    endtask

    task automatic test_close_stop();
        logic [63:0] len;
        len = 64'($urandom_range(3));
        send_frame(1'b1, wsfp_pkg::OP_CLOSE, 1'($urandom_range(1)), ENC_LEN7, len, int'(len));
        repeat (8) send_byte(8'($urandom));
    endtask

    task automatic test_bad_opcode();
        logic [3:0] op;
        do op = 4'($urandom); while (op_legal(op));
        send_byte({$urandom_range(1) == 1, 3'($urandom), op});
        repeat (8) send_byte(8'($urandom));
    endtask

    task automatic test_huge_length();
        send_frame(1'b1, wsfp_pkg::OP_BINARY, 1'b1, ENC_LEN64,
                   {1'b1, 31'($urandom), 32'($urandom)}, 12);
    endtask

    task automatic cmp_field(input string fname, input logic [63:0] exp_v, got_v);
        if (exp_v !== got_v) begin
            n_mismatch++;
            $display("%0t %s: expected %0h, got %0h", $time, fname, exp_v, got_v);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_q.size() == 0) begin
                n_mismatch++;
                $display("%0t result: expected none, got kind %0d data %0h", $time,
                         o_byte_kind, o_payload_out);
            end else begin
                want = expected_q.pop_front();
                cmp_field("byte_kind", 64'(want.kind), 64'(o_byte_kind));
                cmp_field("payload_out", 64'(want.data), 64'(o_payload_out));
                cmp_field("frame_first", 64'(want.first), 64'(o_frame_first));
                cmp_field("frame_last", 64'(want.last), 64'(o_frame_last));
                cmp_field("fin_flag", 64'(want.fin), 64'(o_fin_flag));
                cmp_field("frame_opcode", 64'(want.op), 64'(o_frame_opcode));
                cmp_field("frame_length", want.len, o_frame_length);
                cmp_field("status", 64'(want.st), 64'(o_status));
            end
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("websocket_frame_parser: mismatch");
            $finish;
        end
    end

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        tx_gap_pct = 35;
        rx_stall_pct = 60;
        test_empty_frames();
        test_payload_extremes();
        test_ext_lengths();
        test_random_frames(n_sent + ITEMS_PER_PHASE);

        tx_gap_pct = 60;
        rx_stall_pct = 35;
        test_random_frames(n_sent + ITEMS_PER_PHASE);

        tx_gap_pct = 0;
        rx_stall_pct = 0;
        test_backpressure();
        test_random_frames(n_sent + ITEMS_PER_PHASE);

        // error and close both stop the parser for good, so only one per run
        case ($urandom_range(2))
            0: test_close_stop();
            1: test_bad_opcode();
            default: test_huge_length();
        endcase
        i_valid <= 1'b0;

        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_mismatch == 0) begin
            $display("websocket_frame_parser: match");
        end else begin
            $display("websocket_frame_parser: mismatch");
        end
        $finish;
    end

endmodule
